// ----- rtl/sbct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sbct_pkg;

    localparam int COORD_BITS_DEF     = 20;
    localparam int TIME_FRAC_BITS_DEF = 16;

    // per-lane sideband for one axis time
    typedef struct packed {
        logic neg;  // quotient is negative
        logic vz;   // velocity zero on this axis
        logic hi;   // exit lane (forces +2.0 on zero velocity)
    } lane_ctl_t;

    localparam logic signed [1:0] NORM_POS  = 2'sb01;
    localparam logic signed [1:0] NORM_NEG  = 2'sb11;
    localparam logic signed [1:0] NORM_ZERO = 2'sb00;

endpackage
`default_nettype wire

// ----- rtl/sbct_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sbct_front import sbct_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          en,
    input  wire signed [COORD_BITS-1:0]  ml,
    input  wire signed [COORD_BITS-1:0]  mt,
    input  wire signed [COORD_BITS-1:0]  mr,
    input  wire signed [COORD_BITS-1:0]  mb,
    input  wire signed [COORD_BITS-1:0]  vx,
    input  wire signed [COORD_BITS-1:0]  vy,
    input  wire signed [COORD_BITS-1:0]  sl,
    input  wire signed [COORD_BITS-1:0]  st,
    input  wire signed [COORD_BITS-1:0]  sr,
    input  wire signed [COORD_BITS-1:0]  sb,
    output logic [3:0][COORD_BITS-1:0]   n_reg,
    output logic [3:0][COORD_BITS-1:0]   d_reg,
    output lane_ctl_t [3:0]              ctl_reg,
    output logic                         dx_in_neg_reg,
    output logic                         dy_in_neg_reg
);

    localparam int CB = COORD_BITS;

    logic signed [CB:0] span [4];
    logic signed [CB:0] vxe, vye, vax, vay;
    logic [3:0][CB-1:0]  n_next, d_next;
    lane_ctl_t [3:0]     ctl_next;
    logic                vx_pos, vy_pos;

    function automatic logic signed [CB:0] ext(input logic signed [CB-1:0] a);
        ext = {a[CB-1], a};
    endfunction

    always_comb begin
        vx_pos = (vx > 0);
        vy_pos = (vy > 0);
        // lanes: 0 x entry, 1 x exit, 2 y entry, 3 y exit
        span[0] = vx_pos ? ext(sl) - ext(mr) : ext(sr) - ext(ml);
        span[1] = vx_pos ? ext(sr) - ext(ml) : ext(sl) - ext(mr);
        span[2] = vy_pos ? ext(st) - ext(mb) : ext(sb) - ext(mt);
        span[3] = vy_pos ? ext(sb) - ext(mt) : ext(st) - ext(mb);
        vxe = ext(vx);
        vye = ext(vy);
        vax = vxe[CB] ? -vxe : vxe;
        vay = vye[CB] ? -vye : vye;
        for (int i = 0; i < 4; i++) begin
            logic signed [CB:0] ad;
            ad = span[i][CB] ? -span[i] : span[i];
            n_next[i]      = ad[CB-1:0];
            d_next[i]      = (i < 2) ? vax[CB-1:0] : vay[CB-1:0];
            ctl_next[i].neg = span[i][CB] ^ ((i < 2) ? vx[CB-1] : vy[CB-1]);
            ctl_next[i].vz  = (i < 2) ? (vx == '0) : (vy == '0);
            ctl_next[i].hi  = (i == 1) || (i == 3);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg         <= n_next;
            d_reg         <= d_next;
            ctl_reg       <= ctl_next;
            dx_in_neg_reg <= span[0][CB];
            dy_in_neg_reg <= span[2][CB];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sbct_div_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sbct_div_lane import sbct_pkg::*; #(
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
    input  wire                               aclk,
    input  wire                               en,
    input  wire [COORD_BITS-1:0]              n,
    input  wire [COORD_BITS-1:0]              d,
    input  lane_ctl_t                         ctl,
    output logic signed [TIME_FRAC_BITS+2:0]  t_reg
);

    localparam int CB    = COORD_BITS;
    localparam int F     = TIME_FRAC_BITS;
    localparam int STEPS = F + 2;
    localparam int PW    = CB + 2;
    localparam int QW    = F + 2;
    localparam int TW    = F + 3;
    localparam logic [QW-1:0] SAT = QW'(1) << (F + 1);

    logic [PW-1:0]   p_reg   [STEPS];
    logic [QW-1:0]   q_reg   [STEPS];
    logic [CB-1:0]   d_reg   [STEPS];
    lane_ctl_t       ctl_reg [STEPS];
    logic            ovf_reg [STEPS];

    // one quotient bit per stage, remainder kept scaled by four
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [PW-1:0] p_in, p2, d4;
        logic [QW-1:0] q_in;
        logic [CB-1:0] d_in;
        lane_ctl_t     c_in;
        logic          ovf_in, ge;

        if (k == 0) begin : g_first
            assign p_in   = PW'(n);
            assign q_in   = '0;
            assign d_in   = d;
            assign c_in   = ctl;
            assign ovf_in = (PW'(n) >= {d, 2'b00});
        end else begin : g_rest
            assign p_in   = p_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign c_in   = ctl_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
        end

        assign p2 = {p_in[PW-2:0], 1'b0};
        assign d4 = {d_in, 2'b00};
        assign ge = (p2 >= d4);

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[k]   <= ge ? p2 - d4 : p2;
                q_reg[k]   <= {q_in[QW-2:0], ge};
                d_reg[k]   <= d_in;
                ctl_reg[k] <= c_in;
                ovf_reg[k] <= ovf_in;
            end
        end
    end

    logic [QW:0]          m;
    logic [QW-1:0]        mag;
    logic signed [TW-1:0] t_next;
    lane_ctl_t            cl;

    always_comb begin
        cl = ctl_reg[STEPS-1];
        // floor on a negative quotient with a remainder rounds away from zero
        m   = {1'b0, q_reg[STEPS-1]} +
              (QW+1)'(cl.neg && (p_reg[STEPS-1] != '0));
        mag = (ovf_reg[STEPS-1] || (m > {1'b0, SAT})) ? SAT : m[QW-1:0];
        if (cl.vz) begin
            t_next = cl.hi ? $signed({1'b0, SAT}) : -$signed({1'b0, SAT});
        end else begin
            t_next = cl.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg <= t_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sbct_resolve.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sbct_resolve import sbct_pkg::*; #(
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
    input  wire                               aclk,
    input  wire                               en,
    input  wire signed [TIME_FRAC_BITS+2:0]   tx_in,
    input  wire signed [TIME_FRAC_BITS+2:0]   tx_out,
    input  wire signed [TIME_FRAC_BITS+2:0]   ty_in,
    input  wire signed [TIME_FRAC_BITS+2:0]   ty_out,
    input  wire                               dx_in_neg,
    input  wire                               dy_in_neg,
    output logic [TIME_FRAC_BITS:0]           time_reg,
    output logic signed [1:0]                 nx_reg,
    output logic signed [1:0]                 ny_reg
);

    localparam int F  = TIME_FRAC_BITS;
    localparam int TW = F + 3;
    localparam logic signed [TW-1:0] ONE = TW'(1) << F;

    logic signed [TW-1:0] t_in, t_out;
    logic                 x_first, miss;
    logic [F:0]           time_next;
    logic signed [1:0]    nx_next, ny_next;

    always_comb begin
        x_first = (tx_in > ty_in);
        t_in    = x_first ? tx_in : ty_in;
        t_out   = (tx_out < ty_out) ? tx_out : ty_out;
        miss    = (t_in > t_out) || (tx_in[TW-1] && ty_in[TW-1]) ||
                  (tx_in > ONE) || (ty_in > ONE);
        nx_next = NORM_ZERO;
        ny_next = NORM_ZERO;
        if (miss) begin
            time_next = ONE[F:0];
        end else begin
            time_next = t_in[F:0];
            if (x_first) begin
                nx_next = dx_in_neg ? NORM_POS : NORM_NEG;
            end else begin
                ny_next = dy_in_neg ? NORM_POS : NORM_NEG;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            time_reg <= time_next;
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/swept_box_collision_time.sv -----
// Throughput: one box pair per cycle unless m_ready stalls the output; the four axis
// times run in parallel restoring dividers, one quotient bit per pipeline stage.
// The whole pipeline freezes while a finished result waits on m_ready.
// Reset (aresetn, synchronous, active low) clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module swept_box_collision_time import sbct_pkg::*; #(
    parameter int COORD_BITS     = COORD_BITS_DEF,
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire signed [COORD_BITS-1:0]      s_moving_left,
    input  wire signed [COORD_BITS-1:0]      s_moving_top,
    input  wire signed [COORD_BITS-1:0]      s_moving_right,
    input  wire signed [COORD_BITS-1:0]      s_moving_bottom,
    input  wire signed [COORD_BITS-1:0]      s_vel_x,
    input  wire signed [COORD_BITS-1:0]      s_vel_y,
    input  wire signed [COORD_BITS-1:0]      s_still_left,
    input  wire signed [COORD_BITS-1:0]      s_still_top,
    input  wire signed [COORD_BITS-1:0]      s_still_right,
    input  wire signed [COORD_BITS-1:0]      s_still_bottom,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [TIME_FRAC_BITS:0]          m_hit_time,
    output logic signed [1:0]                m_normal_x,
    output logic signed [1:0]                m_normal_y
);

    localparam int F        = TIME_FRAC_BITS;
    localparam int LANE_LAT = F + 3;
    localparam int LAT      = LANE_LAT + 2;

    logic                       en;
    logic [LAT-1:0]             vld_reg;
    logic [3:0][COORD_BITS-1:0] n_w, d_w;
    lane_ctl_t [3:0]            ctl_w;
    logic                       dxn_w, dyn_w;
    logic signed [F+2:0]        t_w [4];
    logic [LANE_LAT-1:0]        dxn_reg, dyn_reg;

    assign m_valid = vld_reg[LAT-1];
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    sbct_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk          (aclk),
        .en            (en),
        .ml            (s_moving_left),
        .mt            (s_moving_top),
        .mr            (s_moving_right),
        .mb            (s_moving_bottom),
        .vx            (s_vel_x),
        .vy            (s_vel_y),
        .sl            (s_still_left),
        .st            (s_still_top),
        .sr            (s_still_right),
        .sb            (s_still_bottom),
        .n_reg         (n_w),
        .d_reg         (d_w),
        .ctl_reg       (ctl_w),
        .dx_in_neg_reg (dxn_w),
        .dy_in_neg_reg (dyn_w)
    );

    for (genvar i = 0; i < 4; i++) begin : g_lane
        sbct_div_lane #(
            .COORD_BITS     (COORD_BITS),
            .TIME_FRAC_BITS (TIME_FRAC_BITS)
        ) u_div (
            .aclk  (aclk),
            .en    (en),
            .n     (n_w[i]),
            .d     (d_w[i]),
            .ctl   (ctl_w[i]),
            .t_reg (t_w[i])
        );
    end

    // entry distance signs ride alongside the dividers for the normal
    always_ff @(posedge aclk) begin
        if (en) begin
            dxn_reg <= {dxn_reg[LANE_LAT-2:0], dxn_w};
            dyn_reg <= {dyn_reg[LANE_LAT-2:0], dyn_w};
        end
    end

    sbct_resolve #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_resolve (
        .aclk      (aclk),
        .en        (en),
        .tx_in     (t_w[0]),
        .tx_out    (t_w[1]),
        .ty_in     (t_w[2]),
        .ty_out    (t_w[3]),
        .dx_in_neg (dxn_reg[LANE_LAT-1]),
        .dy_in_neg (dyn_reg[LANE_LAT-1]),
        .time_reg  (m_hit_time),
        .nx_reg    (m_normal_x),
        .ny_reg    (m_normal_y)
    );

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import sbct_pkg::*;

    localparam int CB = 20;
    localparam int TF = 16;
    localparam longint T_ONE = 64'sd1 <<< TF;
    localparam longint T_SAT = T_ONE * 2;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1080;

    typedef struct {
        logic signed [CB-1:0] ml, mt, mr, mb, vx, vy, sl, st, sr, sb;
    } box_pair_t;

    typedef struct {
        logic [TF:0]       hit_time;
        logic signed [1:0] nx;
        logic signed [1:0] ny;
    } contact_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CB-1:0] s_ml = '0, s_mt = '0, s_mr = '0, s_mb = '0, s_vx = '0, s_vy = '0;
    logic signed [CB-1:0] s_sl = '0, s_st = '0, s_sr = '0, s_sb = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [TF:0] m_hit_time;
    logic signed [1:0] m_normal_x, m_normal_y;

    box_pair_t pending_pairs[$];
    contact_t  expected_contacts[$];
    int  send_idle_pct = 34;
    int  recv_idle_pct = 56;
    bit  hold_sender = 1'b0;
    bit  stimulus_done = 1'b0;
    bit  in_taken = 1'b0;
    int  mismatches = 0;
    int  checked = 0;
    int  hits_seen = 0;
    int  quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    swept_box_collision_time u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_moving_left(s_ml), .s_moving_top(s_mt), .s_moving_right(s_mr),
        .s_moving_bottom(s_mb), .s_vel_x(s_vx), .s_vel_y(s_vy),
        .s_still_left(s_sl), .s_still_top(s_st), .s_still_right(s_sr),
        .s_still_bottom(s_sb),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit_time(m_hit_time), .m_normal_x(m_normal_x), .m_normal_y(m_normal_y)
    );

    // floor(span * 2^TF / vel), saturated to +-2.0
    function automatic longint axis_time(longint span, longint vel);
        longint num, q, r;
        num = span * T_ONE;
        q = num / vel;
        r = num % vel;
        if (r != 0 && ((r < 0) != (vel < 0)))
            q = q - 1;
        if (q > T_SAT) q = T_SAT;
        if (q < -T_SAT) q = -T_SAT;
        return q;
    endfunction

    function automatic contact_t predict_contact(box_pair_t p);
        contact_t c;
        longint dxi, dxo, dyi, dyo, txi, txo, tyi, tyo, tin, tout;
        if (p.vx > 0) begin
            dxi = longint'(p.sl) - p.mr; dxo = longint'(p.sr) - p.ml;
        end else begin
            dxi = longint'(p.sr) - p.ml; dxo = longint'(p.sl) - p.mr;
        end
        if (p.vy > 0) begin
            dyi = longint'(p.st) - p.mb; dyo = longint'(p.sb) - p.mt;
        end else begin
            dyi = longint'(p.sb) - p.mt; dyo = longint'(p.st) - p.mb;
        end
        if (p.vx == 0) begin
            txi = -T_SAT; txo = T_SAT;
        end else begin
            txi = axis_time(dxi, p.vx); txo = axis_time(dxo, p.vx);
        end
        if (p.vy == 0) begin
            tyi = -T_SAT; tyo = T_SAT;
        end else begin
            tyi = axis_time(dyi, p.vy); tyo = axis_time(dyo, p.vy);
        end
        tin  = (txi > tyi) ? txi : tyi;
        tout = (txo < tyo) ? txo : tyo;
        c.nx = NORM_ZERO;
        c.ny = NORM_ZERO;
        if (tin > tout || (txi < 0 && tyi < 0) || txi > T_ONE || tyi > T_ONE) begin
            c.hit_time = T_ONE[TF:0];
        end else begin
            c.hit_time = tin[TF:0];
            if (txi > tyi)
                c.nx = (dxi < 0) ? NORM_POS : NORM_NEG;
            else
                c.ny = (dyi < 0) ? NORM_POS : NORM_NEG;
        end
        return c;
    endfunction

    function automatic logic signed [CB-1:0] rnd_coord();
        case ($urandom_range(0, 3))
            0: return CB'($urandom);
            1: return CB'($signed($urandom_range(0, 4095)) - 2048);
            default: return CB'($signed($urandom_range(0, 32767)) - 16384);
        endcase
    endfunction

    // mostly well-formed boxes on a course that can meet within a frame; one in ten is fully random
    function automatic box_pair_t rnd_pair();
        box_pair_t p;
        int w, h;
        if ($urandom_range(0, 9) == 0) begin
            p.ml = CB'($urandom); p.mt = CB'($urandom); p.mr = CB'($urandom);
            p.mb = CB'($urandom); p.vx = CB'($urandom); p.vy = CB'($urandom);
            p.sl = CB'($urandom); p.st = CB'($urandom); p.sr = CB'($urandom);
            p.sb = CB'($urandom);
            return p;
        end
        w = $urandom_range(1, 2000); h = $urandom_range(1, 2000);
        p.sl = rnd_coord(); p.st = rnd_coord();
        p.sr = CB'(int'(p.sl) + int'($urandom_range(1, 3000)));
        p.sb = CB'(int'(p.st) + int'($urandom_range(1, 3000)));
        p.ml = CB'(int'(p.sl) + int'($urandom_range(0, 12000)) - 6000);
        p.mt = CB'(int'(p.st) + int'($urandom_range(0, 12000)) - 6000);
        p.mr = CB'(int'(p.ml) + w); p.mb = CB'(int'(p.mt) + h);
        p.vx = CB'(int'(p.sl) - int'(p.ml) + int'($urandom_range(0, 4000)) - 2000);
        p.vy = CB'(int'(p.st) - int'(p.mt) + int'($urandom_range(0, 4000)) - 2000);
        case ($urandom_range(0, 7))
            0: p.vx = '0;
            1: p.vy = '0;
            2: p.vx = CB'($urandom);
            default: ;
        endcase
        return p;
    endfunction

    function automatic box_pair_t make_pair(int ml, int mt, int mr, int mb, int vx, int vy,
                                            int sl, int st, int sr, int sb);
        box_pair_t p;
        p.ml = CB'(ml); p.mt = CB'(mt); p.mr = CB'(mr); p.mb = CB'(mb);
        p.vx = CB'(vx); p.vy = CB'(vy);
        p.sl = CB'(sl); p.st = CB'(st); p.sr = CB'(sr); p.sb = CB'(sb);
        return p;
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (pending_pairs.size() != 0 && !hold_sender &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    box_pair_t p;
                    p = pending_pairs.pop_front();
                    {s_ml, s_mt, s_mr, s_mb, s_vx} = {p.ml, p.mt, p.mr, p.mb, p.vx};
                    {s_vy, s_sl, s_st, s_sr, s_sb} = {p.vy, p.sl, p.st, p.sr, p.sb};
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: sampled on the rising edge
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_contacts.push_back(predict_contact(
                    '{s_ml, s_mt, s_mr, s_mb, s_vx, s_vy, s_sl, s_st, s_sr, s_sb}));
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_valid && m_ready) begin
                contact_t e;
                checked <= checked + 1;
                if (expected_contacts.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected transfer: time=%0d nx=%0d ny=%0d",
                                 m_hit_time, m_normal_x, m_normal_y);
                end else begin
                    e = expected_contacts.pop_front();
                    if (e.hit_time != T_ONE[TF:0]) hits_seen <= hits_seen + 1;
                    if (m_hit_time !== e.hit_time || m_normal_x !== e.nx ||
                        m_normal_y !== e.ny) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display({"mismatch: time exp %0d got %0d, ",
                                      "nx exp %0d got %0d, ny exp %0d got %0d"},
                                     e.hit_time, m_hit_time, e.nx, m_normal_x,
                                     e.ny, m_normal_y);
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || s_valid || expected_contacts.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero velocities, field extremes, each entry side, misses
        pending_pairs.push_back(make_pair(0, 0, 16, 16, 0, 0, 32, 0, 48, 16));
        pending_pairs.push_back(make_pair(0, 0, 16, 16, 32, 0, 32, 0, 48, 16));
        pending_pairs.push_back(make_pair(64, 0, 80, 16, -32, 0, 32, 0, 48, 16));
        pending_pairs.push_back(make_pair(0, 0, 16, 16, 0, 32, 0, 32, 16, 48));
        pending_pairs.push_back(make_pair(0, 64, 16, 80, 0, -32, 0, 32, 16, 48));
        pending_pairs.push_back(make_pair(0, 0, 16, 16, 32, 32, 24, 24, 48, 48));
        pending_pairs.push_back(make_pair(0, 0, 16, 16, 32, 0, 32, 500, 48, 516));
        pending_pairs.push_back(make_pair(0, 0, 16, 16, 8, 0, 32, 0, 48, 16));
        pending_pairs.push_back(make_pair(0, 0, 16, 16, 16, 0, 32, 0, 48, 16));
        pending_pairs.push_back(make_pair(0, 0, 16, 16, 3, 7, 8, 8, 40, 40));
        pending_pairs.push_back(make_pair(20, 20, 10, 10, 5, -5, 0, 30, 8, 25));
        pending_pairs.push_back(make_pair(-524288, -524288, -524288, -524288, 524287, 524287,
                                          524287, 524287, 524287, 524287));
        pending_pairs.push_back(make_pair(524287, 524287, 524287, 524287, -524288, -524288,
                                          -524288, -524288, -524288, -524288));
        pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        pending_pairs.push_back(make_pair(-524288, 0, 524287, 16, 1, 0, -524288, 0, 524287, 16));
        pending_pairs.push_back(make_pair(0, 0, 1, 1, -524288, 524287, -524288, 0, -1, 1));
        pending_pairs.push_back(make_pair(0, 0, 16, 16, 24, 24, 20, 20, 40, 40));

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 34; recv_idle_pct = 56; end
                1: begin send_idle_pct = 56; recv_idle_pct = 34; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int i = 0; i < N_RANDOM / 3; i++)
                pending_pairs.push_back(rnd_pair());
            if (phase == 0) begin
                // sender holds off until the pipe has emptied
                while (pending_pairs.size() > 200) @(posedge aclk);
                hold_sender = 1'b1;
                while (s_valid || expected_contacts.size() != 0) @(posedge aclk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end
        stimulus_done = 1'b1;
        repeat (TF + 40) @(posedge aclk);

        $display("covered %0d box pairs (%0d hits) over three back-pressure mixes",
                 checked, hits_seen);
        if (mismatches == 0 && expected_contacts.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sbct_pkg.sv
rtl/sbct_front.sv
rtl/sbct_div_lane.sv
rtl/sbct_resolve.sv
rtl/swept_box_collision_time.sv
dv/testbench.sv
